// ===== hw/rtl/rle565_pkg.sv =====
// ----------------------------------------------------------------------------
// rle565_pkg
// shared types and constants for the rgb565 run-length pixel decoder
// ----------------------------------------------------------------------------
package rle565_pkg;

    localparam int unsigned PIX_W     = 16;
    localparam int unsigned RUN_W     = 16;
    localparam int unsigned CFG_IDX_W = 3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_RLE_MODE       = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_KEY_ENABLE     = t_cfg_idx'(1);
    localparam t_cfg_idx CFG_KEY_COLOR      = t_cfg_idx'(2);
    localparam t_cfg_idx CFG_BACKDROP_COLOR = t_cfg_idx'(3);
    localparam t_cfg_idx CFG_TINT_ENABLE    = t_cfg_idx'(4);
    localparam t_cfg_idx CFG_TINT_COLOR     = t_cfg_idx'(5);

    localparam logic [RUN_W-1:0] RUN_ONE = RUN_W'(1);

    typedef struct packed {
        logic             rle_mode;
        logic             key_enable;
        logic [PIX_W-1:0] key_color;
        logic [PIX_W-1:0] backdrop_color;
        logic             tint_enable;
        logic [PIX_W-1:0] tint_color;
    } t_cfg;

    typedef struct packed {
        logic             emit;
        logic [PIX_W-1:0] color;
        logic [RUN_W-1:0] run_length;
    } t_run;

endpackage

// ===== hw/rtl/rle565_pixel_decode_tint.sv =====
// ----------------------------------------------------------------------------
// rle565_pixel_decode_tint
// rgb565 run-length pixel decoder with colour key and tint
//
// words of an image body enter on the s_axis channel, tuser marking the
// first word of an image; pixel runs leave on m_axis as colour and length.
// registers are written on the cfg channel (always ready); the user must
// write them only while idle, as the block itself does not enforce it.
// an input register feeds the run decision and colour logic, whose result
// lands in the output register that drives m_axis_tvalid and m_axis_tdata;
// one word accepted per cycle sustained while the receiver does not stall.
// a count word that gives no copies is consumed without any output.
// when the receiver stalls, the output register holds its run and the
// input register still takes one more word before s_axis_tready drops.
// reset (synchronous, active low) clears the configuration registers, the
// run state and both pipeline valid flags.
// ----------------------------------------------------------------------------
module rle565_pixel_decode_tint
    import rle565_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [PIX_W-1:0]       s_axis_tdata,   // word
    input  logic                   s_axis_tuser,   // image_start
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [PIX_W+RUN_W-1:0] m_axis_tdata,   // color, run_length
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  t_cfg_idx               i_cfg_addr,
    input  logic [PIX_W-1:0]       i_cfg_data
);

    t_cfg             cfg;
    t_run             run;
    logic [PIX_W-1:0] fin_color;
    logic             out_free;
    logic             fire;

    logic             r_in_vld;
    logic [PIX_W-1:0] r_in_word;
    logic             r_in_start;
    logic             r_out_vld;
    logic [PIX_W-1:0] r_out_color;
    logic [RUN_W-1:0] r_out_len;

    rle565_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    rle565_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_word        (r_in_word),
        .i_image_start (r_in_start),
        .i_rle_mode    (cfg.rle_mode),
        .o_run         (run)
    );

    rle565_tint u_tint (
        .i_cfg   (cfg),
        .i_color (run.color),
        .o_color (fin_color)
    );

    assign out_free      = !r_out_vld || m_axis_tready;
    assign fire          = r_in_vld && out_free;
    assign s_axis_tready = !r_in_vld || out_free;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out_len, r_out_color};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_word  <= s_axis_tdata;
            r_in_start <= s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= fire && run.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && run.emit) begin
            r_out_color <= fin_color;
            r_out_len   <= run.run_length;
        end
    end

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[PIX_W+RUN_W-1:PIX_W] != '0))
        else $error("run of zero length on output");

    a_raw_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !cfg.rle_mode) |=>
            (m_axis_tvalid && (m_axis_tdata[PIX_W+RUN_W-1:PIX_W] == RUN_ONE)))
        else $error("raw word did not give a single pixel");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_out_vld && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken with both stages full");

    a_plain_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && run.emit && !cfg.key_enable && !cfg.tint_enable) |=>
            (m_axis_tdata[PIX_W-1:0] == $past(run.color)))
        else $error("colour altered with key and tint off");

endmodule

// ===== hw/rtl/rle565_cfg.sv =====
// ----------------------------------------------------------------------------
// rle565_cfg
// configuration register file, written one register per transaction
// ----------------------------------------------------------------------------
module rle565_cfg
    import rle565_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  t_cfg_idx         i_cfg_addr,
    input  logic [PIX_W-1:0] i_cfg_data,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                CFG_RLE_MODE:       r_cfg.rle_mode       <= i_cfg_data[0];
                CFG_KEY_ENABLE:     r_cfg.key_enable     <= i_cfg_data[0];
                CFG_KEY_COLOR:      r_cfg.key_color      <= i_cfg_data;
                CFG_BACKDROP_COLOR: r_cfg.backdrop_color <= i_cfg_data;
                CFG_TINT_ENABLE:    r_cfg.tint_enable    <= i_cfg_data[0];
                CFG_TINT_COLOR:     r_cfg.tint_color     <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ===== hw/rtl/rle565_parse.sv =====
// ----------------------------------------------------------------------------
// rle565_parse
// run-length state and run decision for one word per cycle, advanced only on i_fire
// ----------------------------------------------------------------------------
module rle565_parse
    import rle565_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [PIX_W-1:0] i_word,
    input  logic             i_image_start,
    input  logic             i_rle_mode,
    output t_run             o_run
);

    logic [PIX_W-1:0] r_last_color;
    logic             r_count_expected;
    logic             r_started;
    logic [PIX_W-1:0] n_last_color;
    logic             n_count_expected;
    logic             n_started;
    logic [RUN_W-1:0] count_m1;

    assign count_m1 = i_word - RUN_ONE;

    always_comb begin
        n_last_color     = r_last_color;
        n_count_expected = r_count_expected;
        n_started        = r_started;
        o_run.emit       = 1'b1;
        o_run.color      = i_word;
        o_run.run_length = RUN_ONE;
        if (!i_rle_mode) begin
            if (i_image_start) begin
                n_started        = 1'b0;
                n_count_expected = 1'b0;
            end
        end else if (i_image_start || !r_started) begin
            n_started        = 1'b1;
            n_count_expected = 1'b0;
            n_last_color     = i_word;
        end else if (r_count_expected) begin
            n_count_expected = 1'b0;
            o_run.emit       = (count_m1 != '0);
            o_run.color      = r_last_color;
            o_run.run_length = count_m1;
        end else begin
            n_count_expected = (i_word == r_last_color);
            n_last_color     = i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_color     <= '0;
            r_count_expected <= 1'b0;
            r_started        <= 1'b0;
        end else if (i_fire) begin
            r_last_color     <= n_last_color;
            r_count_expected <= n_count_expected;
            r_started        <= n_started;
        end
    end

endmodule

// ===== hw/rtl/rle565_tint.sv =====
// ----------------------------------------------------------------------------
// rle565_tint
// colour keying followed by per-channel averaging with the tint colour
// ----------------------------------------------------------------------------
module rle565_tint
    import rle565_pkg::*;
(
    input  t_cfg             i_cfg,
    input  logic [PIX_W-1:0] i_color,
    output logic [PIX_W-1:0] o_color
);

    logic [PIX_W-1:0] keyed;
    logic [5:0]       sum_r;
    logic [6:0]       sum_g;
    logic [5:0]       sum_b;

    assign keyed = (i_cfg.key_enable && (i_color == i_cfg.key_color)) ?
                   i_cfg.backdrop_color : i_color;

    assign sum_r = {1'b0, keyed[15:11]} + {1'b0, i_cfg.tint_color[15:11]};
    assign sum_g = {1'b0, keyed[10:5]}  + {1'b0, i_cfg.tint_color[10:5]};
    assign sum_b = {1'b0, keyed[4:0]}   + {1'b0, i_cfg.tint_color[4:0]};

    assign o_color = i_cfg.tint_enable ? {sum_r[5:1], sum_g[6:1], sum_b[5:1]} : keyed;

endmodule

// ===== bench/rle565_run_checker.sv =====
// ----------------------------------------------------------------------------
// rle565_run_checker
// predicts the pixel runs of the rgb565 run-length decoder and compares them
//
// follows register writes and input transactions, and keeps its own copy of
// the run state. for every accepted word it queues the run that is due, then
// checks each output transaction field by field against the oldest entry.
// the fail count and the number of outstanding runs go back to the bench top.
// ----------------------------------------------------------------------------
module rle565_run_checker
    import rle565_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [PIX_W-1:0]       s_axis_tdata,   // word
    input  logic                   s_axis_tuser,   // image_start
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [PIX_W+RUN_W-1:0] m_axis_tdata,   // color, run_length
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  t_cfg_idx               i_cfg_addr,
    input  logic [PIX_W-1:0]       i_cfg_data,
    output int                     o_fail_count,
    output int                     o_runs_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [PIX_W-1:0] color;
        logic [RUN_W-1:0] run_length;
    } t_pixel_run;

    t_cfg             regs;
    logic [PIX_W-1:0] prev_word;
    logic             count_due;
    logic             image_open;
    t_pixel_run       runs_due [$];
    t_pixel_run       want;
    t_pixel_run       got;
    bit               has_run;

    // key first, then average each channel with the tint
    function automatic logic [PIX_W-1:0] shade(input logic [PIX_W-1:0] c);
        logic [PIX_W-1:0] keyed;
        logic [5:0]       r;
        logic [6:0]       g;
        logic [5:0]       b;
        keyed = (regs.key_enable && c == regs.key_color) ? regs.backdrop_color : c;
        if (!regs.tint_enable)
            return keyed;
        r = {1'b0, keyed[15:11]} + {1'b0, regs.tint_color[15:11]};
        g = {1'b0, keyed[10:5]}  + {1'b0, regs.tint_color[10:5]};
        b = {1'b0, keyed[4:0]}   + {1'b0, regs.tint_color[4:0]};
        return {r[5:1], g[6:1], b[5:1]};
    endfunction

    function automatic bit decode_word(input logic [PIX_W-1:0] w, input logic img_start,
                                       output t_pixel_run run);
        run.color      = shade(w);
        run.run_length = RUN_ONE;
        if (!regs.rle_mode) begin
            if (img_start) begin
                image_open = 1'b0;
                count_due  = 1'b0;
            end
            return 1'b1;
        end
        if (img_start || !image_open) begin
            image_open = 1'b1;
            count_due  = 1'b0;
            prev_word  = w;
            return 1'b1;
        end
        if (count_due) begin
            count_due      = 1'b0;
            run.color      = shade(prev_word);
            run.run_length = w - RUN_ONE;
            return run.run_length != '0;
        end
        count_due = (w == prev_word);
        prev_word = w;
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs       = '0;
            prev_word  = '0;
            count_due  = 1'b0;
            image_open = 1'b0;
            runs_due.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.color      = m_axis_tdata[PIX_W-1:0];
                got.run_length = m_axis_tdata[PIX_W +: RUN_W];
                if (runs_due.size() == 0) begin
                    $error("unexpected run transaction: color %h, run_length %0d",
                           got.color, got.run_length);
                    o_fail_count++;
                end else begin
                    want = runs_due.pop_front();
                    if (got.color !== want.color) begin
                        $error("color: expected %h, actual %h", want.color, got.color);
                        o_fail_count++;
                    end
                    if (got.run_length !== want.run_length) begin
                        $error("run_length: expected %0d, actual %0d",
                               want.run_length, got.run_length);
                        o_fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                has_run = decode_word(s_axis_tdata, s_axis_tuser, want);
                if (has_run)
                    runs_due.push_back(want);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_addr)
                    CFG_RLE_MODE:       regs.rle_mode       = i_cfg_data[0];
                    CFG_KEY_ENABLE:     regs.key_enable     = i_cfg_data[0];
                    CFG_KEY_COLOR:      regs.key_color      = i_cfg_data;
                    CFG_BACKDROP_COLOR: regs.backdrop_color = i_cfg_data;
                    CFG_TINT_ENABLE:    regs.tint_enable    = i_cfg_data[0];
                    CFG_TINT_COLOR:     regs.tint_color     = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_runs_pending = runs_due.size();
    end

endmodule

// ===== bench/rle565_pixel_decode_tint_tb.sv =====
// ----------------------------------------------------------------------------
// rle565_pixel_decode_tint_tb
// regression bench for the rgb565 run-length pixel decoder
//
// a short directed pass covers raw words, colour key, tint extremes, repeat
// counts of zero, one and full range, and an image start cutting a pending
// count. random phases then stream mostly well-formed run-length images
// under changing register settings, with sender gaps and receiver stalls.
// the checker module predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module rle565_pixel_decode_tint_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rle565_pkg::*;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [PIX_W-1:0]       s_axis_tdata  = '0;   // word
    logic                   s_axis_tuser  = 1'b0; // image_start
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [PIX_W+RUN_W-1:0] m_axis_tdata;         // color, run_length
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    t_cfg_idx               i_cfg_addr    = CFG_RLE_MODE;
    logic [PIX_W-1:0]       i_cfg_data    = '0;

    int               fail_count;
    int               runs_pending;
    int               send_idle_pct = 0;
    int               stall_pct     = 0;
    logic [PIX_W-1:0] palette [4];

    rle565_pixel_decode_tint dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    rle565_run_checker chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_runs_pending (runs_pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic t_cfg make_cfg(input logic rle, input logic key_en,
                                      input logic [PIX_W-1:0] key,
                                      input logic [PIX_W-1:0] bg,
                                      input logic tint_en,
                                      input logic [PIX_W-1:0] tint);
        t_cfg c;
        c.rle_mode       = rle;
        c.key_enable     = key_en;
        c.key_color      = key;
        c.backdrop_color = bg;
        c.tint_enable    = tint_en;
        c.tint_color     = tint;
        return c;
    endfunction

    function automatic logic [PIX_W-1:0] any_color();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] next_color();
        if ($urandom_range(1))
            return palette[$urandom_range(3)];
        return PIX_W'($urandom);
    endfunction

    function automatic logic [PIX_W-1:0] next_count();
        case ($urandom_range(9))
            0:       return '0;
            1:       return PIX_W'(1);
            2:       return '1;
            3:       return PIX_W'(2);
            4:       return PIX_W'($urandom);
            default: return PIX_W'($urandom_range(40, 3));
        endcase
    endfunction

    task automatic send_word(input logic [PIX_W-1:0] w, input logic img_start);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tuser  <= img_start;
        @(negedge i_clk);
        while (!s_axis_tready)
            @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // hold the sender until every queued run has left, then let the pipe drain
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (runs_pending != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_config(input t_cfg c);
        t_cfg_idx         idxs [6];
        logic [PIX_W-1:0] vals [6];
        idxs = '{CFG_RLE_MODE, CFG_KEY_ENABLE, CFG_KEY_COLOR,
                 CFG_BACKDROP_COLOR, CFG_TINT_ENABLE, CFG_TINT_COLOR};
        vals = '{PIX_W'(c.rle_mode), PIX_W'(c.key_enable), c.key_color,
                 c.backdrop_color, PIX_W'(c.tint_enable), c.tint_color};
        for (int k = 0; k < 6; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_addr  <= idxs[k];
            i_cfg_data  <= vals[k];
            @(negedge i_clk);
            while (!o_cfg_ready)
                @(negedge i_clk);
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic stream_images(input int budget);
        logic [PIX_W-1:0] w;
        int               sent;
        sent = 0;
        while (sent < budget) begin
            case ($urandom_range(19))
                0: begin
                    send_word(PIX_W'($urandom), 1'($urandom_range(1)));
                    sent += 1;
                end
                1: begin
                    send_word(next_color(), 1'b1);
                    sent += 1;
                end
                2, 3, 4, 5, 6, 7: begin
                    w = next_color();
                    send_word(w, 1'b0);
                    send_word(w, 1'b0);
                    send_word(next_count(), 1'b0);
                    sent += 3;
                end
                8: begin
                    // repeat pair left without its count
                    w = next_color();
                    send_word(w, 1'b0);
                    send_word(w, 1'b0);
                    sent += 2;
                end
                default: begin
                    send_word(next_color(), 1'b0);
                    sent += 1;
                end
            endcase
        end
    endtask

    initial begin
        t_cfg c;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // raw words with colour key
        load_config(make_cfg(1'b0, 1'b1, 16'h0000, 16'hFFFF, 1'b0, 16'h0000));
        send_word(16'h0000, 1'b1);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'hA5C3, 1'b1);
        settle();

        // run-length with full tint, no image start yet
        load_config(make_cfg(1'b1, 1'b0, 16'h0000, 16'h0000, 1'b1, 16'hFFFF));
        send_word(16'hF800, 1'b0);
        send_word(16'hF800, 1'b0);
        send_word(16'h0005, 1'b0);
        send_word(16'h07E0, 1'b0);
        send_word(16'h07E0, 1'b0);
        send_word(16'h0001, 1'b0);
        send_word(16'h001F, 1'b0);
        send_word(16'h001F, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h1111, 1'b1);
        send_word(16'h1111, 1'b0);
        send_word(16'h0002, 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'hFFFF, 1'b0);
        settle();

        // key then tint towards black
        load_config(make_cfg(1'b1, 1'b1, 16'h1234, 16'h8410, 1'b1, 16'h0000));
        send_word(16'h1234, 1'b1);
        send_word(16'h1234, 1'b0);
        send_word(16'h0003, 1'b0);
        send_word(16'h5555, 1'b0);
        settle();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: c = make_cfg(1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0, 16'h0000);
                1: c = make_cfg(1'b1, 1'b1, 16'hFFFF, 16'h0000, 1'b1, 16'hFFFF);
                2: c = make_cfg(1'b0, 1'b1, 16'h0000, 16'hFFFF, 1'b1, 16'h0000);
                default: c = make_cfg(1'($urandom_range(3) != 0), 1'($urandom_range(1)),
                                      any_color(), any_color(),
                                      1'($urandom_range(1)), any_color());
            endcase
            load_config(c);
            palette[0] = c.key_color;
            palette[1] = PIX_W'($urandom);
            palette[2] = PIX_W'($urandom);
            palette[3] = any_color();
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct <= 0;  end
                1: begin send_idle_pct = 48; stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  stall_pct <= 48; end
                default: begin send_idle_pct = 10; stall_pct <= 10; end
            endcase
            stream_images(114);
            settle();
            stream_images(114);
            settle();
        end

        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (runs_pending != 0)
            @(negedge i_clk);
        repeat (20) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #2ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
